// ----- sv/ddsw_pkg.sv -----
`timescale 1ns / 1ps

package ddsw_pkg;

  // field widths
  localparam int unsigned TEMP_W = 15;
  localparam int unsigned CAP_W  = 14;
  localparam int unsigned ACC_W  = 21;
  localparam int unsigned DAY_W  = 9;

  localparam logic [DAY_W-1:0] DAY_MAX = '1;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  localparam int unsigned DAYS_PER_YEAR_DEF = 365;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = ACC_W;

  localparam logic [CFG_IDX_W-1:0] REG_HATCH_BASE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HATCH_CAP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HATCH_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PUPATE_BASE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PUPATE_CAP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PUPATE_THRESHOLD = 3'd5;

  // register reset values, hundredths of a degree
  localparam logic [TEMP_W-1:0] HATCH_BASE_RST       = 15'd300;
  localparam logic [CAP_W-1:0]  HATCH_CAP_RST        = 14'd3700;
  localparam logic [ACC_W-1:0]  HATCH_THRESHOLD_RST  = 21'd31700;
  localparam logic [TEMP_W-1:0] PUPATE_BASE_RST      = 15'd765;
  localparam logic [CAP_W-1:0]  PUPATE_CAP_RST       = 14'd3335;
  localparam logic [ACC_W-1:0]  PUPATE_THRESHOLD_RST = 21'd58650;

  typedef enum logic [1:0] {
    PH_HATCH  = 2'd0,
    PH_PUPATE = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // bases are two's complement bit patterns
  typedef struct packed {
    logic [TEMP_W-1:0] hatch_base;
    logic [CAP_W-1:0]  hatch_cap;
    logic [ACC_W-1:0]  hatch_threshold;
    logic [TEMP_W-1:0] pupate_base;
    logic [CAP_W-1:0]  pupate_cap;
    logic [ACC_W-1:0]  pupate_threshold;
  } cfg_t;

  typedef struct packed {
    logic [DAY_W-1:0] hatch_day;
    logic [DAY_W-1:0] pupate_day;
    logic [DAY_W-1:0] active_days;
    logic             hatched;
    logic             pupated;
  } res_t;

endpackage

// ----- sv/ddsw_if.sv -----
`timescale 1ns / 1ps

interface ddsw_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ddsw_pkg::TEMP_W-1:0]  temperature;
  logic                                year_end;

  modport source (output valid, output temperature, output year_end, input ready);
  modport sink (input valid, input temperature, input year_end, output ready);
endinterface

interface ddsw_out_if;
  logic                        valid;
  logic                        ready;
  logic [ddsw_pkg::DAY_W-1:0]  hatch_day;
  logic [ddsw_pkg::DAY_W-1:0]  pupate_day;
  logic [ddsw_pkg::DAY_W-1:0]  active_days;
  logic                        hatched;
  logic                        pupated;

  modport source (
    output valid, output hatch_day, output pupate_day, output active_days,
    output hatched, output pupated, input ready
  );
  modport sink (
    input valid, input hatch_day, input pupate_day, input active_days,
    input hatched, input pupated, output ready
  );
endinterface

// ----- sv/ddsw_cfg_regs.sv -----
`timescale 1ns / 1ps

module ddsw_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ddsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ddsw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output ddsw_pkg::cfg_t                      cfg
);

  ddsw_pkg::cfg_t cfg_r;
  ddsw_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ddsw_pkg::REG_HATCH_BASE:
          cfg_nxt.hatch_base = cfg_wdata[ddsw_pkg::TEMP_W-1:0];
        ddsw_pkg::REG_HATCH_CAP:
          cfg_nxt.hatch_cap = cfg_wdata[ddsw_pkg::CAP_W-1:0];
        ddsw_pkg::REG_HATCH_THRESHOLD:
          cfg_nxt.hatch_threshold = cfg_wdata[ddsw_pkg::ACC_W-1:0];
        ddsw_pkg::REG_PUPATE_BASE:
          cfg_nxt.pupate_base = cfg_wdata[ddsw_pkg::TEMP_W-1:0];
        ddsw_pkg::REG_PUPATE_CAP:
          cfg_nxt.pupate_cap = cfg_wdata[ddsw_pkg::CAP_W-1:0];
        ddsw_pkg::REG_PUPATE_THRESHOLD:
          cfg_nxt.pupate_threshold = cfg_wdata[ddsw_pkg::ACC_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hatch_base       <= ddsw_pkg::HATCH_BASE_RST;
      cfg_r.hatch_cap        <= ddsw_pkg::HATCH_CAP_RST;
      cfg_r.hatch_threshold  <= ddsw_pkg::HATCH_THRESHOLD_RST;
      cfg_r.pupate_base      <= ddsw_pkg::PUPATE_BASE_RST;
      cfg_r.pupate_cap       <= ddsw_pkg::PUPATE_CAP_RST;
      cfg_r.pupate_threshold <= ddsw_pkg::PUPATE_THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/ddsw_season_core.sv -----
`timescale 1ns / 1ps

module ddsw_season_core #(
  parameter int unsigned DAYS_PER_YEAR = ddsw_pkg::DAYS_PER_YEAR_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ddsw_pkg::cfg_t                     cfg,
  input  logic                               step,
  input  logic [ddsw_pkg::TEMP_W-1:0]        temperature,
  input  logic                               year_end,
  output logic                               res_valid,
  output ddsw_pkg::res_t                     res
);

  localparam int unsigned TW = ddsw_pkg::TEMP_W;
  localparam int unsigned CW = ddsw_pkg::CAP_W;
  localparam int unsigned AW = ddsw_pkg::ACC_W;
  localparam int unsigned DW = ddsw_pkg::DAY_W;

  ddsw_pkg::phase_t phase_r, phase_nxt;
  logic [AW-1:0]    acc_r, acc_nxt;
  logic [DW-1:0]    day_r, day_nxt;
  logic [DW-1:0]    hatch_day_r, hatch_day_nxt;

  logic [DW-1:0]    day_inc;
  logic             last_day;
  logic             in_phase;
  logic [TW-1:0]    base;
  logic [CW-1:0]    cap;
  logic [AW-1:0]    thr;
  logic signed [TW:0] diff;
  logic [CW-1:0]    gain;
  logic [AW:0]      sum_wide;
  logic [AW-1:0]    sum_sat;
  logic             crossed;

  function automatic ddsw_pkg::res_t make_res(
    input logic [DW-1:0] hd,
    input logic [DW-1:0] pd,
    input logic          h,
    input logic          p
  );
    ddsw_pkg::res_t r;
    r.hatch_day   = hd;
    r.pupate_day  = pd;
    r.active_days = (pd >= hd) ? DW'(pd - hd) : '0;
    r.hatched     = h;
    r.pupated     = p;
    return r;
  endfunction

  // daily contribution: clamp(temp - base, 0, cap), then saturating add
  always_comb begin
    day_inc  = (day_r < ddsw_pkg::DAY_MAX) ? DW'(day_r + 1'b1) : day_r;
    last_day = year_end || (day_inc >= DW'(DAYS_PER_YEAR));
    in_phase = (phase_r == ddsw_pkg::PH_HATCH) || (phase_r == ddsw_pkg::PH_PUPATE);
    if (phase_r == ddsw_pkg::PH_HATCH) begin
      base = cfg.hatch_base;
      cap  = cfg.hatch_cap;
      thr  = cfg.hatch_threshold;
    end else begin
      base = cfg.pupate_base;
      cap  = cfg.pupate_cap;
      thr  = cfg.pupate_threshold;
    end
    diff = $signed({temperature[TW-1], temperature}) - $signed({base[TW-1], base});
    if (diff[TW]) begin
      gain = '0;
    end else if (diff[TW-1:0] > TW'(cap)) begin
      gain = cap;
    end else begin
      gain = diff[CW-1:0];
    end
    sum_wide = {1'b0, acc_r} + (AW+1)'(gain);
    sum_sat  = sum_wide[AW] ? ddsw_pkg::ACC_MAX : sum_wide[AW-1:0];
    crossed  = in_phase && (sum_sat > thr);
  end

  // phase sequencing and result
  always_comb begin
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    day_nxt       = day_r;
    hatch_day_nxt = hatch_day_r;
    res_valid     = 1'b0;
    res           = make_res(day_inc, day_inc, 1'b0, 1'b0);
    if (step) begin
      day_nxt = day_inc;
      if (in_phase) begin
        acc_nxt = sum_sat;
      end
      if (crossed) begin
        acc_nxt = '0;
        case (phase_r)
          ddsw_pkg::PH_HATCH: begin
            hatch_day_nxt = day_inc;
            phase_nxt     = ddsw_pkg::PH_PUPATE;
          end
          default: begin
            res       = make_res(hatch_day_r, day_inc, 1'b1, 1'b1);
            res_valid = 1'b1;
            phase_nxt = ddsw_pkg::PH_DONE;
          end
        endcase
      end
      if (last_day) begin
        case (phase_nxt)
          ddsw_pkg::PH_HATCH: begin
            res       = make_res(day_inc, day_inc, 1'b0, 1'b0);
            res_valid = 1'b1;
          end
          ddsw_pkg::PH_PUPATE: begin
            res       = make_res(hatch_day_nxt, day_inc, 1'b1, 1'b0);
            res_valid = 1'b1;
          end
          default: ;
        endcase
        phase_nxt     = ddsw_pkg::PH_HATCH;
        acc_nxt       = '0;
        day_nxt       = '0;
        hatch_day_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ddsw_pkg::PH_HATCH;
      acc_r       <= '0;
      day_r       <= '0;
      hatch_day_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      day_r       <= day_nxt;
      hatch_day_r <= hatch_day_nxt;
    end
  end

`ifndef ASSERT_OFF
  // the year restarts before the day count reaches its length
  a_day_in_year: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, day_r} < (DW+1)'(DAYS_PER_YEAR))
    else $error("day count reached year length without restart");

  // waiting for pupation implies a recorded hatch day
  a_hatch_recorded: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ddsw_pkg::PH_PUPATE |-> hatch_day_r != '0)
    else $error("pupation phase without hatch day");

  // accumulator clears on every phase change
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r != phase_nxt |=> acc_r == '0)
    else $error("accumulator not cleared on phase change");
`endif

endmodule

// ----- sv/degree_day_season_window.sv -----
`timescale 1ns / 1ps

// degree-day season window
// in_ch carries one day per beat: signed temperature in hundredths of a
// degree and year_end, which marks the last day of the year. a day is also
// the last once the day count reaches DAYS_PER_YEAR.
// out_ch carries at most one result per year: hatch and pupation day
// offsets, the active days between them and the hatched/pupated flags.
// the result comes on the pupation day, or on the last day if pupation
// was not reached; other days give no beat.
// cfg_we/cfg_index/cfg_wdata write the six base/cap/threshold registers,
// one per clock; write them only while no day is in flight.
// a day taken into the input register is evaluated once the result register
// is free, and its result is then held in the result register.
// throughput: one day per cycle while out_ch is not stalled; the input register
// and the result register each hold one beat, evaluation is one clamp, add and
// compare. a stall on out_ch holds the result register, and in_ch keeps
// taking a beat only while the input register is empty.
// reset: registers take their default values, the year restarts and both
// channels are empty.
module degree_day_season_window #(
  parameter int unsigned DAYS_PER_YEAR = ddsw_pkg::DAYS_PER_YEAR_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ddsw_in_if.sink                          in_ch,
  ddsw_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [ddsw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ddsw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ddsw_pkg::cfg_t cfg;

  // input register
  logic                         in_valid_r, in_valid_nxt;
  logic [ddsw_pkg::TEMP_W-1:0]  temp_r;
  logic                         year_end_r;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  ddsw_pkg::res_t               res_r;

  logic                         out_free;
  logic                         step;
  logic                         in_take;
  logic                         res_valid;
  ddsw_pkg::res_t               res;

  ddsw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ddsw_season_core #(
    .DAYS_PER_YEAR (DAYS_PER_YEAR)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .step        (step),
    .temperature (temp_r),
    .year_end    (year_end_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result slot is free when empty or being taken this cycle
  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    // a day without a result still empties the result slot it was given
    if (step) begin
      out_valid_nxt = res_valid;
    end else begin
      out_valid_nxt = out_valid_r && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      temp_r     <= in_ch.temperature;
      year_end_r <= in_ch.year_end;
    end
    if (step && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hatch_day   = res_r.hatch_day;
  assign out_ch.pupate_day  = res_r.pupate_day;
  assign out_ch.active_days = res_r.active_days;
  assign out_ch.hatched     = res_r.hatched;
  assign out_ch.pupated     = res_r.pupated;

`ifndef ASSERT_OFF
  // no pupation without hatch
  a_pupate_needs_hatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.hatched |-> !res_r.pupated)
    else $error("pupated without hatch");

  // without hatch both offsets are the days seen
  a_no_hatch_days: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.hatched |->
      res_r.hatch_day == res_r.pupate_day && res_r.active_days == '0)
    else $error("offsets differ without hatch");

  // active days span hatch to pupation
  a_active_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> res_r.pupate_day >= res_r.hatch_day &&
      res_r.active_days == ddsw_pkg::DAY_W'(res_r.pupate_day - res_r.hatch_day))
    else $error("active days inconsistent");
`endif

endmodule

// ----- tb/season_window_checker.sv -----
`timescale 1ns / 1ps

module season_window_checker
  import ddsw_pkg::*;
#(
  parameter int unsigned YEAR_LEN = DAYS_PER_YEAR_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ddsw_in_if                    in_mon,
  ddsw_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    seasons_pending,
  output int                    seasons_checked,
  output int                    pupations_seen
);

  // shadow registers and season state
  cfg_t             regs;
  phase_t           phase;
  logic [ACC_W-1:0] dd_sum;
  logic [DAY_W-1:0] day_cnt;
  logic [DAY_W-1:0] hatch_at;
  res_t             season_q[$];
  int               errs;
  int               checked;
  int               pupated_n;

  function automatic logic [ACC_W-1:0] daily_gain(input logic signed [TEMP_W-1:0] temp,
                                                  input logic [TEMP_W-1:0] base,
                                                  input logic [CAP_W-1:0] cap);
    int diff;
    int lim;
    diff = int'(temp) - int'($signed(base));
    lim  = int'(cap);
    if (diff < 0) return '0;
    if (diff > lim) return ACC_W'(cap);
    return ACC_W'(diff);
  endfunction

  function automatic res_t season_result(input logic [DAY_W-1:0] hd,
                                         input logic [DAY_W-1:0] pd,
                                         input logic h, input logic p);
    res_t r;
    r.hatch_day   = hd;
    r.pupate_day  = pd;
    r.active_days = (pd >= hd) ? pd - hd : '0;
    r.hatched     = h;
    r.pupated     = p;
    return r;
  endfunction

  task automatic restart_year();
    phase    = PH_HATCH;
    dd_sum   = '0;
    day_cnt  = '0;
    hatch_at = '0;
  endtask

  task automatic advance_day(input logic signed [TEMP_W-1:0] temp, input logic year_end);
    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] thr;
    logic             last;
    if (day_cnt != DAY_MAX) day_cnt = day_cnt + 1'b1;
    last = year_end || (day_cnt >= YEAR_LEN);
    if (phase == PH_HATCH || phase == PH_PUPATE) begin
      if (phase == PH_HATCH) begin
        sum = dd_sum + daily_gain(temp, regs.hatch_base, regs.hatch_cap);
        thr = regs.hatch_threshold;
      end else begin
        sum = dd_sum + daily_gain(temp, regs.pupate_base, regs.pupate_cap);
        thr = regs.pupate_threshold;
      end
      if (sum > ACC_MAX) sum = ACC_MAX;
      dd_sum = sum[ACC_W-1:0];
      if (sum > thr) begin
        dd_sum = '0;
        if (phase == PH_HATCH) begin
          hatch_at = day_cnt;
          phase    = PH_PUPATE;
        end else begin
          season_q.push_back(season_result(hatch_at, day_cnt, 1'b1, 1'b1));
          phase = PH_DONE;
        end
      end
    end
    if (last) begin
      if (phase == PH_HATCH) begin
        season_q.push_back(season_result(day_cnt, day_cnt, 1'b0, 1'b0));
      end else if (phase == PH_PUPATE) begin
        season_q.push_back(season_result(hatch_at, day_cnt, 1'b1, 1'b0));
      end
      restart_year();
    end
  endtask

  // bits above a register's width are dropped, unknown indexes ignored
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_HATCH_BASE:       regs.hatch_base       = data[TEMP_W-1:0];
      REG_HATCH_CAP:        regs.hatch_cap        = data[CAP_W-1:0];
      REG_HATCH_THRESHOLD:  regs.hatch_threshold  = data[ACC_W-1:0];
      REG_PUPATE_BASE:      regs.pupate_base      = data[TEMP_W-1:0];
      REG_PUPATE_CAP:       regs.pupate_cap       = data[CAP_W-1:0];
      REG_PUPATE_THRESHOLD: regs.pupate_threshold = data[ACC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_season();
    res_t want;
    res_t got;
    got.hatch_day   = out_mon.hatch_day;
    got.pupate_day  = out_mon.pupate_day;
    got.active_days = out_mon.active_days;
    got.hatched     = out_mon.hatched;
    got.pupated     = out_mon.pupated;
    if (season_q.size() == 0) begin
      $error("unexpected result beat: hatch_day %0d pupate_day %0d", got.hatch_day,
             got.pupate_day);
      errs++;
    end else begin
      want = season_q.pop_front();
      checked++;
      if (want.pupated) pupated_n++;
      if (got.hatch_day !== want.hatch_day) begin
        $error("hatch_day mismatch: expected %0d, actual %0d", want.hatch_day, got.hatch_day);
        errs++;
      end
      if (got.pupate_day !== want.pupate_day) begin
        $error("pupate_day mismatch: expected %0d, actual %0d", want.pupate_day,
               got.pupate_day);
        errs++;
      end
      if (got.active_days !== want.active_days) begin
        $error("active_days mismatch: expected %0d, actual %0d", want.active_days,
               got.active_days);
        errs++;
      end
      if (got.hatched !== want.hatched) begin
        $error("hatched mismatch: expected %0b, actual %0b", want.hatched, got.hatched);
        errs++;
      end
      if (got.pupated !== want.pupated) begin
        $error("pupated mismatch: expected %0b, actual %0b", want.pupated, got.pupated);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '{HATCH_BASE_RST, HATCH_CAP_RST, HATCH_THRESHOLD_RST,
               PUPATE_BASE_RST, PUPATE_CAP_RST, PUPATE_THRESHOLD_RST};
      restart_year();
      season_q.delete();
    end else begin
      // a result beat can never belong to the day taken at the same edge
      if (out_mon.valid && out_mon.ready) check_season();
      if (in_mon.valid && in_mon.ready) advance_day(in_mon.temperature, in_mon.year_end);
      if (cfg_we) write_reg(cfg_index, cfg_wdata);
    end
    mismatch_count  <= errs;
    seasons_pending <= season_q.size();
    seasons_checked <= checked;
    pupations_seen  <= pupated_n;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// drives days into the season window, stalls the result side at random and
// leaves all prediction and comparison to the checker beside the block
module tb;
  import ddsw_pkg::*;

  localparam int unsigned YEAR_LEN = DAYS_PER_YEAR_DEF;

  // spare index past the register list, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

  localparam logic [TEMP_W-1:0] BASE_MOST_NEG = {1'b1, {(TEMP_W-1){1'b0}}};
  localparam logic [TEMP_W-1:0] BASE_MOST_POS = {1'b0, {(TEMP_W-1){1'b1}}};

  // opening days, run with a small known setting (bases 0, hatch cap 10000
  // over 10000, pupation cap 5000 over 9999):
  //   cold single-day year, no hatch
  //   hatch on day 2 by one hundredth, pupation day 4, quiet days after it
  //   hatch on the marked last day, no pupation
  //   temperatures outside the usual range, pupation on the last day itself
  //   hatch, then pupation falling just short at year end
  localparam int N_OPENING = 20;
  localparam int OPENING_TEMP [N_OPENING] = '{
    -10000,
    10000, 1, 10000, 5000, 0, -1,
    10000, 10000,
    -16384, 16383, 16383, -16384, 16383, 16383,
    10000, 10000, 4999, 4999, 0
  };
  localparam bit OPENING_LAST [N_OPENING] = '{
    1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1
  };

  localparam int N_SHUFFLED = 6;    // random register settings
  localparam int SHUFFLED_DAYS = 50; // day budget per random setting

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ddsw_in_if  in_ch ();
  ddsw_out_if out_ch ();

  int   mismatch_count;
  int   seasons_pending;
  int   seasons_checked;
  int   pupations_seen;

  cfg_t season_cfg;   // what the registers hold, steers the temperatures
  bit   steady;       // no gaps on either side during this stretch
  int   days_sent;
  int   reg_sets;

  degree_day_season_window #(
    .DAYS_PER_YEAR(YEAR_LEN)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  season_window_checker #(
    .YEAR_LEN(YEAR_LEN)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .seasons_pending(seasons_pending),
    .seasons_checked(seasons_checked),
    .pupations_seen (pupations_seen)
  );

  always #2 clk = ~clk;

  // gap length in cycles: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // year lengths kept short so results come often
  function automatic int pick_year_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 6);
    if (roll < 97) return $urandom_range(7, 24);
    return $urandom_range(25, 60);
  endfunction

  // a good share of days lands around one of the bases, from 300 below it to 300
  // past its cap, so both phases see zero, partial and capped contributions
  function automatic int pick_temp();
    int roll;
    int anchor;
    int cap;
    int t;
    roll = $urandom_range(0, 9);
    if (roll < 4) return int'($urandom_range(0, 20000)) - 10000;
    if (roll < 7) begin
      anchor = int'($signed(season_cfg.hatch_base));
      cap    = int'(season_cfg.hatch_cap);
    end else begin
      anchor = int'($signed(season_cfg.pupate_base));
      cap    = int'(season_cfg.pupate_cap);
    end
    t = anchor + int'($urandom_range(0, cap + 600)) - 300;
    if (t > 10000) t = 10000;
    if (t < -10000) t = -10000;
    return t;
  endfunction

  function automatic logic [TEMP_W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0: return BASE_MOST_NEG;
      1: return BASE_MOST_POS;
      2: return TEMP_W'(-10000);
      3: return TEMP_W'(10000);
      default: return TEMP_W'(int'($urandom_range(0, 20000)) - 10000);
    endcase
  endfunction

  function automatic logic [CAP_W-1:0] pick_cap();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CAP_W'(10000);
      default: return CAP_W'($urandom_range(1, 10000));
    endcase
  endfunction

  // a handful of capped days crosses it, save for the two extremes
  function automatic logic [ACC_W-1:0] pick_threshold(input logic [CAP_W-1:0] cap);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ACC_MAX;
      default: return ACC_W'(int'(cap) * int'($urandom_range(0, 5))
                             + int'($urandom_range(0, int'(cap))));
    endcase
  endfunction

  // result side: ready drops for random stretches unless steady
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n || hold > 0) begin
        out_ch.ready <= 1'b0;
        if (hold > 0) hold--;
      end else begin
        out_ch.ready <= 1'b1;
        hold = steady ? 0 : pick_gap();
      end
    end
  end

  // one register per edge; the enable is dropped once after the last one
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // junk above the narrow registers must be dropped by the block
  task automatic load_regs(input cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    put_reg(REG_HATCH_BASE,       {junk[CFG_DATA_W-1:TEMP_W], c.hatch_base});
    put_reg(REG_HATCH_CAP,        {junk[CFG_DATA_W-1:CAP_W], c.hatch_cap});
    put_reg(REG_HATCH_THRESHOLD,  c.hatch_threshold);
    put_reg(REG_PUPATE_BASE,      {junk[CFG_DATA_W-1:TEMP_W], c.pupate_base});
    put_reg(REG_PUPATE_CAP,       {junk[CFG_DATA_W-1:CAP_W], c.pupate_cap});
    put_reg(REG_PUPATE_THRESHOLD, c.pupate_threshold);
    put_reg(REG_SPARE,            junk);
    cfg_we <= 1'b0;
    season_cfg = c;
    reg_sets++;
  endtask

  // one day beat, with an optional gap in front; valid stays up afterwards
  task automatic send_day(input int temp, input bit last);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.temperature <= TEMP_W'(temp);
    in_ch.year_end    <= last;
    do @(posedge clk); while (!in_ch.ready);
    days_sent++;
  endtask

  // complete years with random weather until the day budget is spent
  task automatic run_years(input int budget);
    int first;
    int len;
    first = days_sent;
    while (days_sent - first < budget) begin
      len = pick_year_len();
      for (int d = 1; d <= len; d++) send_day(pick_temp(), d == len);
    end
  endtask

  // hold the sender until every expected season has come back, then give a
  // day that makes no result time to leave the block
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (seasons_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    cfg_t c;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.temperature = '0;
    in_ch.year_end    = 1'b0;
    steady            = 1'b0;
    days_sent         = 0;
    reg_sets          = 1;
    season_cfg = '{HATCH_BASE_RST, HATCH_CAP_RST, HATCH_THRESHOLD_RST,
                   PUPATE_BASE_RST, PUPATE_CAP_RST, PUPATE_THRESHOLD_RST};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // registers at their reset values
    run_years(40);
    settle();

    // opening days against a small known setting
    c.hatch_base       = '0;
    c.hatch_cap        = CAP_W'(10000);
    c.hatch_threshold  = ACC_W'(10000);
    c.pupate_base      = '0;
    c.pupate_cap       = CAP_W'(5000);
    c.pupate_threshold = ACC_W'(9999);
    load_regs(c);
    for (int i = 0; i < N_OPENING; i++) send_day(OPENING_TEMP[i], OPENING_LAST[i]);
    settle();

    // a full-length year without a marked end: widest gain every day drives
    // the sum into saturation, and a maxed threshold is never crossed
    c.hatch_base       = BASE_MOST_NEG;
    c.hatch_cap        = '1;
    c.hatch_threshold  = ACC_MAX;
    c.pupate_base      = BASE_MOST_POS;
    c.pupate_cap       = '0;
    c.pupate_threshold = '0;
    load_regs(c);
    steady = 1'b1;
    for (int d = 1; d <= int'(YEAR_LEN); d++) send_day($urandom_range(0, 10000), 1'b0);
    steady = 1'b0;
    // the next days start a fresh year
    for (int d = 1; d <= 3; d++) send_day(pick_temp(), d == 3);
    settle();

    // random settings, extremes included, each followed by a full drain
    for (int p = 0; p < N_SHUFFLED; p++) begin
      c.hatch_base       = pick_base();
      c.hatch_cap        = pick_cap();
      c.hatch_threshold  = pick_threshold(c.hatch_cap);
      c.pupate_base      = pick_base();
      c.pupate_cap       = pick_cap();
      c.pupate_threshold = pick_threshold(c.pupate_cap);
      load_regs(c);
      steady = ($urandom_range(0, 3) == 0);
      run_years(SHUFFLED_DAYS);
      settle();
    end
    steady = 1'b0;

    $display("covered %0d days under %0d register settings, a full-length saturating year among them",
             days_sent, reg_sets);
    $display("checked %0d season results, %0d of them reaching pupation",
             seasons_checked, pupations_seen);
    if (mismatch_count == 0 && seasons_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // a correct run with every gap and stall at its longest stays far below
  // this, roughly 750 days in all
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ddsw_pkg.sv
sv/ddsw_if.sv
sv/ddsw_cfg_regs.sv
sv/ddsw_season_core.sv
sv/degree_day_season_window.sv
tb/season_window_checker.sv
tb/tb.sv
